[sv/ipaddr_pkg.sv]
// Shared types and constants of the address text parser.
package ipaddr_pkg;

   localparam int OCTET_COUNT = 4;
   localparam int GROUP_COUNT = 8;

   localparam logic [3:0] FIELD_MAX        = 4'd15;
   localparam logic [3:0] OCTET_LAST_INDEX = 4'd3;
   localparam logic [3:0] OCTET_LIMIT      = 4'd4;
   localparam logic [3:0] GROUP_LIMIT      = 4'd8;
   localparam logic [3:0] LETTER_OFFSET    = 4'd9;

   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F  = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F  = 8'h46;
   localparam logic [7:0] CHAR_DOT      = 8'h2e;
   localparam logic [7:0] CHAR_COLON    = 8'h3a;

   typedef struct packed {
      logic [OCTET_COUNT-1:0][7:0]  octets;
      logic [GROUP_COUNT-1:0][15:0] groups;
      logic [7:0]                   decimal_accum;
      logic [15:0]                  hex_accum;
      logic [3:0]                   field_index;
      logic [3:0]                   gap_position;
      logic                         dot;
      logic                         gap;
      logic                         colon;
      logic                         err;
   } parse_record_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [3:0] field_bump(input logic [3:0] idx);
      field_bump = (idx == FIELD_MAX) ? FIELD_MAX : idx + 4'd1;
   endfunction

endpackage

[sv/ipaddr_channels.sv]
// Handshake channel interfaces for characters in and addresses out.
interface ipaddr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, char_code, last_char, input ready);
   modport sink (input valid, char_code, last_char, output ready);
endinterface

interface ipaddr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] addr_high;
   logic [63:0] addr_low;
   logic        is_v6;
   logic        malformed;

   modport source (output valid, addr_high, addr_low, is_v6, malformed, input ready);
   modport sink (input valid, addr_high, addr_low, is_v6, malformed, output ready);
endinterface

[sv/ipaddr_front.sv]
// Character intake: classify each character and update the parse state.
module ipaddr_front (
   input  logic                          clock,
   input  logic                          reset,
   ipaddr_req_if.sink                    req_channel,
   input  ipaddr_pkg::queue_status_type  queue_status,
   output logic                          push_valid,
   output ipaddr_pkg::parse_record_type  push_record
);

   ipaddr_pkg::parse_record_type state_ff, state_in;
   logic                         letter_ff, letter_in;

   logic       accept;
   logic       was_colon;
   logic       is_digit;
   logic       is_letter;
   logic [7:0] c;
   logic [3:0] digit;
   ipaddr_pkg::parse_record_type next;

   assign req_channel.ready = !queue_status.full;
   assign accept = req_channel.valid && req_channel.ready;
   assign c = req_channel.char_code;
   assign is_digit = (c >= ipaddr_pkg::CHAR_ZERO) && (c <= ipaddr_pkg::CHAR_NINE);
   assign is_letter = ((c >= ipaddr_pkg::CHAR_LOWER_A) && (c <= ipaddr_pkg::CHAR_LOWER_F)) ||
                      ((c >= ipaddr_pkg::CHAR_UPPER_A) && (c <= ipaddr_pkg::CHAR_UPPER_F));
   assign digit = is_digit ? c[3:0] : ({1'b0, c[2:0]} + ipaddr_pkg::LETTER_OFFSET);

   always_comb begin
      next = state_ff;
      letter_in = letter_ff;
      was_colon = state_ff.colon;
      if (accept) begin
         next.colon = 1'b0;
         if (is_digit) begin
            next.decimal_accum = 8'(state_ff.decimal_accum * 8'd10 + {4'b0, digit});
            next.hex_accum = {state_ff.hex_accum[11:0], digit};
         end else if (is_letter) begin
            next.hex_accum = {state_ff.hex_accum[11:0], digit};
            letter_in = 1'b1;
            if (state_ff.dot) next.err = 1'b1;
         end else if (c == ipaddr_pkg::CHAR_DOT) begin
            if (letter_ff || state_ff.gap || was_colon ||
                (!state_ff.dot && state_ff.field_index != 4'd0)) next.err = 1'b1;
            next.dot = 1'b1;
            if (state_ff.field_index < ipaddr_pkg::OCTET_LIMIT)
               next.octets[state_ff.field_index[1:0]] = state_ff.decimal_accum;
            else
               next.err = 1'b1;
            next.field_index = ipaddr_pkg::field_bump(state_ff.field_index);
            next.decimal_accum = '0;
            next.hex_accum = '0;
         end else if (c == ipaddr_pkg::CHAR_COLON) begin
            if (state_ff.dot) next.err = 1'b1;
            if (was_colon) begin
               if (state_ff.gap) next.err = 1'b1;
               next.gap = 1'b1;
               next.gap_position = state_ff.field_index;
            end else begin
               if (state_ff.field_index < ipaddr_pkg::GROUP_LIMIT)
                  next.groups[state_ff.field_index[2:0]] = state_ff.hex_accum;
               else
                  next.err = 1'b1;
               next.field_index = ipaddr_pkg::field_bump(state_ff.field_index);
            end
            next.colon = 1'b1;
            next.decimal_accum = '0;
            next.hex_accum = '0;
         end else begin
            next.err = 1'b1;
         end
      end
      push_valid = accept && req_channel.last_char;
      push_record = next;
      state_in = next;
      if (push_valid) begin
         state_in = '0;
         letter_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         letter_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         letter_ff <= letter_in;
      end
   end

endmodule

[sv/ipaddr_queue.sv]
// Two-entry queue of finished parse records between intake and assembly.
module ipaddr_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  ipaddr_pkg::parse_record_type  push_record,
   input  logic                          pop,
   output ipaddr_pkg::parse_record_type  head_record,
   output ipaddr_pkg::queue_status_type  queue_status
);

   ipaddr_pkg::parse_record_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign queue_status.full = (count_ff == 2'd2);
   assign queue_status.empty = (count_ff == 2'd0);
   assign head_record = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_valid;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + {1'b0, push_valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push_valid) entry_ff[wr_ptr_ff] <= push_record;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

[sv/ipaddr_back.sv]
// Address assembly: close the last field, expand the gap and register the transaction.
module ipaddr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  ipaddr_pkg::parse_record_type  head_record,
   input  ipaddr_pkg::queue_status_type  queue_status,
   output logic                          pop,
   ipaddr_rsp_if.source                  rsp_channel
);

   logic        valid_ff, valid_in;
   logic [63:0] high_ff, high_in;
   logic [63:0] low_ff, low_in;
   logic        v6_ff, v6_in;
   logic        bad_ff, bad_in;

   always_comb begin
      logic [ipaddr_pkg::OCTET_COUNT-1:0][7:0]  oct;
      logic [ipaddr_pkg::GROUP_COUNT-1:0][15:0] grp;
      logic [15:0] full [ipaddr_pkg::GROUP_COUNT];
      logic [3:0]  idx2;
      logic [3:0]  cnt;
      logic [3:0]  gp;
      logic [3:0]  shift;
      logic [3:0]  lane;
      logic [3:0]  src;
      logic        err4;
      logic        err6;

      oct = head_record.octets;
      if (head_record.field_index < ipaddr_pkg::OCTET_LIMIT)
         oct[head_record.field_index[1:0]] = head_record.decimal_accum;
      err4 = head_record.err || (head_record.field_index != ipaddr_pkg::OCTET_LAST_INDEX);

      grp = head_record.groups;
      err6 = head_record.err;
      idx2 = head_record.field_index;
      if (head_record.colon) begin
         if (!(head_record.gap && head_record.gap_position == head_record.field_index))
            err6 = 1'b1;
      end else begin
         if (head_record.field_index < ipaddr_pkg::GROUP_LIMIT)
            grp[head_record.field_index[2:0]] = head_record.hex_accum;
         else
            err6 = 1'b1;
         idx2 = ipaddr_pkg::field_bump(head_record.field_index);
      end
      if (head_record.gap) begin
         if (idx2 > ipaddr_pkg::GROUP_LIMIT) err6 = 1'b1;
      end else begin
         if (idx2 != ipaddr_pkg::GROUP_LIMIT) err6 = 1'b1;
      end
      cnt = (idx2 > ipaddr_pkg::GROUP_LIMIT) ? ipaddr_pkg::GROUP_LIMIT : idx2;
      gp = head_record.gap ? head_record.gap_position : cnt;
      if (gp > cnt) gp = cnt;
      shift = ipaddr_pkg::GROUP_LIMIT - cnt;
      for (int j = 0; j < ipaddr_pkg::GROUP_COUNT; j++) begin
         lane = 4'(j);
         src = lane - shift;
         if (lane < gp)
            full[j] = grp[j];
         else if (lane >= shift + gp)
            full[j] = grp[src[2:0]];
         else
            full[j] = '0;
      end

      pop = !queue_status.empty && (!valid_ff || rsp_channel.ready);
      valid_in = valid_ff && !rsp_channel.ready;
      high_in = high_ff;
      low_in = low_ff;
      v6_in = v6_ff;
      bad_in = bad_ff;
      if (pop) begin
         valid_in = 1'b1;
         v6_in = !head_record.dot;
         if (head_record.dot) begin
            high_in = '0;
            low_in = {32'b0, oct[0], oct[1], oct[2], oct[3]};
            bad_in = err4;
         end else begin
            high_in = {full[0], full[1], full[2], full[3]};
            low_in = {full[4], full[5], full[6], full[7]};
            bad_in = err6;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      high_ff <= high_in;
      low_ff <= low_in;
      v6_ff <= v6_in;
      bad_ff <= bad_in;
   end

   assign rsp_channel.valid = valid_ff;
   assign rsp_channel.addr_high = high_ff;
   assign rsp_channel.addr_low = low_ff;
   assign rsp_channel.is_v6 = v6_ff;
   assign rsp_channel.malformed = bad_ff;

endmodule

[sv/ip_address_text_parser.sv]
// Top level of the IPv4 / IPv6 address text parser.
//
// req_channel takes one character of address text per transaction, with
// last_char marking the final character. A text holding a dot is read as
// dotted IPv4, any other as IPv6 hex groups with at most one "::".
// rsp_channel returns one transaction per text: the 128-bit address split
// into addr_high and addr_low (IPv4 in addr_low[31:0]), is_v6 and malformed.
// Characters are taken one per cycle while the queue is not full; the
// intake updates the parse state in the cycle it takes a character. The
// last character pushes the parse record into a two-entry queue, and the
// assembly stage closes the final field, expands the gap and registers
// the address. The assembly stage takes one record per cycle while its
// output register is empty or rsp_channel is ready.
// When rsp_channel stalls, the output register holds, the queue fills and
// req_channel ready drops only once two records wait in it.
// Reset clears the parse state, the queue and the output valid.
module ip_address_text_parser (
   input  logic          clock,
   input  logic          reset,
   ipaddr_req_if.sink    req_channel,
   ipaddr_rsp_if.source  rsp_channel
);

   logic                         push_valid;
   ipaddr_pkg::parse_record_type push_record;
   logic                         pop;
   ipaddr_pkg::parse_record_type head_record;
   ipaddr_pkg::queue_status_type queue_status;

   ipaddr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_channel  (req_channel),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_record  (push_record)
   );

   ipaddr_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_valid   (push_valid),
      .push_record  (push_record),
      .pop          (pop),
      .head_record  (head_record),
      .queue_status (queue_status)
   );

   ipaddr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_record  (head_record),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_channel  (rsp_channel)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      queue_status.full |-> !push_valid)
      else $error("record pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty)
      else $error("record taken from an empty queue");

   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_channel.valid)
      else $error("assembled address not presented");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_channel.valid)
      else $error("result valid after reset");

endmodule
